// ===== sv/lfu_pkg.sv =====
package lfu_pkg;
  localparam int Slots = 32;
  localparam int SlotW = 5;
  localparam int CountW = 16;
  localparam int OccW = 6;

  localparam logic [2:0] KIND_HIT = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_REPLACE = 3'd2;
  localparam logic [2:0] KIND_REPORT = 3'd3;
  localparam logic [2:0] KIND_EMPTY = 3'd4;

  localparam logic CMD_VOTE = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef struct packed {
    logic [7:0] key;
    logic [CountW-1:0] count;
    logic [SlotW-1:0] age;
  } entry_t;
endpackage

// ===== sv/lfu_slot_replacement_unit.sv =====
// Vote: S_SCAN visits all 32 slots, then S_COMMIT registers the result and updates the slots.
// Report: for each held key, a full scan in S_RSCAN and then an output in S_RPUT, up to 32 results;
// a single report-empty result when nothing is held.
// The next item is taken only after the final result is accepted and the unit is back in S_IDLE.
// A result stalled for longer than one scan holds back the next report entry.
// Synchronous active-high rst clears valid bits, occupancy, control; capacity resets to 20.
module lfu_slot_replacement_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic        cmd,
  input  logic [7:0]  key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  result_key,
  output logic [7:0]  evicted_key,
  output logic [15:0] hit_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);
  import lfu_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_COMMIT = 5'b00100,
    S_RSCAN  = 5'b01000,
    S_RPUT   = 5'b10000
  } state_t;

  state_t state;
  entry_t slot [Slots];
  logic [Slots-1:0] slot_valid;
  logic [OccW-1:0] occupied;
  logic [5:0] slots_in_use;
  logic [SlotW-1:0] idx;
  logic [7:0] op_key;
  logic match_found, free_found, vic_found, best_found;
  logic [SlotW-1:0] match_idx, free_idx, vic_idx, best_idx;
  logic [8:0] prev_key;
  logic [OccW-1:0] n_out;
  logic [OccW-1:0] cap;
  entry_t cur, vic, best;

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign stall = (state != S_IDLE) || out_valid;
  assign cur = slot[idx];
  assign vic = slot[vic_idx];
  assign best = slot[best_idx];

  always_comb begin
    cap = slots_in_use;
    if (slots_in_use == '0) cap = OccW'(1);
    if (slots_in_use > OccW'(Slots)) cap = OccW'(Slots);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      occupied <= '0;
      slots_in_use <= 6'd20;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) slots_in_use <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (valid && !stall) begin
            op_key <= key;
            idx <= '0;
            match_found <= 1'b0;
            free_found <= 1'b0;
            vic_found <= 1'b0;
            best_found <= 1'b0;
            prev_key <= 9'h1FF;
            n_out <= '0;
            state <= (cmd == CMD_REPORT) ? S_RSCAN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (slot_valid[idx]) begin
            if (cur.key == op_key) begin
              match_found <= 1'b1;
              match_idx <= idx;
            end
            if (!vic_found || cur.count < vic.count ||
                (cur.count == vic.count && cur.age < vic.age)) begin
              vic_found <= 1'b1;
              vic_idx <= idx;
            end
          end else if (!free_found) begin
            free_found <= 1'b1;
            free_idx <= idx;
          end
          idx <= idx + SlotW'(1);
          if (idx == SlotW'(Slots - 1)) state <= S_COMMIT;
        end
        S_COMMIT: begin
          result_key <= op_key;
          evicted_key <= '0;
          last <= 1'b1;
          out_valid <= 1'b1;
          state <= S_IDLE;
          if (match_found) begin
            kind <= KIND_HIT;
            if (slot[match_idx].count != '1) begin
              slot[match_idx].count <= slot[match_idx].count + CountW'(1);
              hit_count <= slot[match_idx].count + CountW'(1);
            end else hit_count <= slot[match_idx].count;
          end else if (occupied < cap && free_found) begin
            kind <= KIND_INSERT;
            hit_count <= 16'd1;
            slot_valid[free_idx] <= 1'b1;
            slot[free_idx] <= '{key: op_key, count: CountW'(1), age: SlotW'(occupied)};
            occupied <= occupied + OccW'(1);
          end else begin
            kind <= KIND_REPLACE;
            hit_count <= 16'd1;
            evicted_key <= vic.key;
            for (int i = 0; i < Slots; i++)
              if (slot_valid[i] && slot[i].age > vic.age)
                slot[i].age <= slot[i].age - SlotW'(1);
            slot[vic_idx] <= '{key: op_key, count: CountW'(1),
                               age: SlotW'(occupied - OccW'(1))};
          end
        end
        S_RSCAN: begin
          if (slot_valid[idx] &&
              (prev_key == 9'h1FF || cur.key > prev_key[7:0]) &&
              (!best_found || cur.key < best.key)) begin
            best_found <= 1'b1;
            best_idx <= idx;
          end
          idx <= idx + SlotW'(1);
          if (idx == SlotW'(Slots - 1)) state <= S_RPUT;
        end
        S_RPUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            evicted_key <= '0;
            if (best_found) begin
              kind <= KIND_REPORT;
              result_key <= best.key;
              hit_count <= best.count;
              last <= (n_out + OccW'(1) == occupied);
              n_out <= n_out + OccW'(1);
              prev_key <= {1'b0, best.key};
              best_found <= 1'b0;
              state <= (n_out + OccW'(1) == occupied) ? S_IDLE : S_RSCAN;
            end else begin
              kind <= KIND_EMPTY;
              result_key <= '0;
              hit_count <= '0;
              last <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) occupied <= OccW'(Slots))
    else $error("occupancy overflow");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !out_valid) else $error("result pending during scan");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> stall) else $error("accept while busy");
endmodule
